### src/tcg_pkg.sv
// Shared types, widths and register codes for the triangle color gradient shader.
// Used by every module of the shader core; depends on nothing.
package tcg_pkg;

  // Only the low CoordBits bits of a pixel coordinate take part in the mapping.
  localparam int CoordBits = 12;
  localparam int PixW      = 12;
  localparam int CoordW    = (CoordBits < PixW) ? CoordBits : PixW;
  localparam int OddW      = CoordW + 1;

  localparam int CoefW     = 32;
  localparam int MapProdW  = CoefW + OddW + 1;
  localparam int UvW       = 47;
  localparam int MapSumW   = (MapProdW + 2 > UvW + 1) ? MapProdW + 2 : UvW + 1;

  localparam int LaneW     = 16;
  localparam int LaneCnt   = 4;
  localparam int AlphaLane = 3;
  localparam int ChProdW   = UvW + LaneW;
  localparam int ChW       = ChProdW + 1;
  localparam int BaseShift = 17;

  localparam int MagW      = ChW - 1;
  localparam int HalfW     = 32;
  localparam int MagHiW    = MagW - HalfW;
  localparam int MidW      = HalfW + MagHiW + 1;
  localparam int HsW       = 2 * MagHiW + HalfW;

  localparam int QW        = 47;
  localparam int ScaleW    = 17;
  localparam int TW        = QW + ScaleW;
  localparam int ByteW     = 8;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  localparam logic [ScaleW-1:0] AlphaOne = ScaleW'(1) << (ScaleW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegBaseColor  = 3'd0,
    RegColorStepU = 3'd1,
    RegColorStepV = 3'd2,
    RegMapU       = 3'd3,
    RegMapV       = 3'd4,
    RegMapOffsets = 3'd5,
    RegAlphaScale = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgDataW-1:0] base_color;
    logic [CfgDataW-1:0] color_step_u;
    logic [CfgDataW-1:0] color_step_v;
    logic [CfgDataW-1:0] map_u_coeffs;
    logic [CfgDataW-1:0] map_v_coeffs;
    logic [CfgDataW-1:0] map_offsets;
    logic [ScaleW-1:0]   alpha_scale;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
    logic            span_end;
  } pix_in_t;

  typedef struct packed {
    logic [4*ByteW-1:0] pixel_argb;
    logic               span_end_out;
  } pix_out_t;

  typedef struct packed {
    logic [UvW-1:0] u;
    logic [UvW-1:0] v;
    logic           span_end;
  } uv_t;

  typedef struct packed {
    logic [LaneCnt-1:0][ChW-1:0] ch;
    logic                        span_end;
  } chan_t;

  typedef struct packed {
    logic [LaneCnt-1:0][QW-1:0] q;
    logic [LaneCnt-1:0]         big;
    logic                       span_end;
  } qval_t;

endpackage

### src/tcg_map.sv
// Maps a pixel center through the inverse affine matrix to saturated (u, v).
// Two register stages; depends on tcg_pkg.
module tcg_map (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcg_pkg::cfg_t    cfg_i,
  input  logic             valid_i,
  input  tcg_pkg::pix_in_t pix_i,
  output logic             valid_o,
  output tcg_pkg::uv_t     uv_o
);

  logic [tcg_pkg::OddW-1:0] x2, y2;

  logic signed [tcg_pkg::MapProdW-1:0] pux_d, puy_d, pvx_d, pvy_d;
  logic signed [tcg_pkg::MapProdW-1:0] pux_q, puy_q, pvx_q, pvy_q;
  logic                                span1_q, valid1_q;

  logic signed [tcg_pkg::MapSumW-1:0] sum_u, sum_v;
  tcg_pkg::uv_t                       uv_d, uv_q;
  logic                               valid2_q;

  function automatic logic [tcg_pkg::UvW-1:0] sat_uv(
    input logic signed [tcg_pkg::MapSumW-1:0] s
  );
    logic [tcg_pkg::MapSumW-tcg_pkg::UvW:0] top;
    logic [tcg_pkg::UvW-1:0]                res;
    top = s[tcg_pkg::MapSumW-1:tcg_pkg::UvW-1];
    if ((&top) || (~|top)) begin
      res = s[tcg_pkg::UvW-1:0];
    end else if (s[tcg_pkg::MapSumW-1]) begin
      res = {1'b1, {(tcg_pkg::UvW-1){1'b0}}};
    end else begin
      res = {1'b0, {(tcg_pkg::UvW-1){1'b1}}};
    end
    return res;
  endfunction

  // Pixel center doubled: 2x+1 and 2y+1, so u and v carry 17 fraction bits.
  assign x2 = {pix_i.pixel_x[tcg_pkg::CoordW-1:0], 1'b1};
  assign y2 = {pix_i.pixel_y[tcg_pkg::CoordW-1:0], 1'b1};

  assign pux_d = $signed(cfg_i.map_u_coeffs[63:32]) * $signed({1'b0, x2});
  assign puy_d = $signed(cfg_i.map_u_coeffs[31:0])  * $signed({1'b0, y2});
  assign pvx_d = $signed(cfg_i.map_v_coeffs[63:32]) * $signed({1'b0, x2});
  assign pvy_d = $signed(cfg_i.map_v_coeffs[31:0])  * $signed({1'b0, y2});

  assign sum_u = tcg_pkg::MapSumW'(pux_q) + tcg_pkg::MapSumW'(puy_q)
               + (tcg_pkg::MapSumW'($signed(cfg_i.map_offsets[63:32])) <<< 1);
  assign sum_v = tcg_pkg::MapSumW'(pvx_q) + tcg_pkg::MapSumW'(pvy_q)
               + (tcg_pkg::MapSumW'($signed(cfg_i.map_offsets[31:0])) <<< 1);

  always_comb begin
    uv_d.u        = sat_uv(sum_u);
    uv_d.v        = sat_uv(sum_v);
    uv_d.span_end = span1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pux_q   <= pux_d;
    puy_q   <= puy_d;
    pvx_q   <= pvx_d;
    pvy_q   <= pvy_d;
    span1_q <= pix_i.span_end;
    uv_q    <= uv_d;
  end

  assign valid_o = valid2_q;
  assign uv_o    = uv_q;

endmodule

### src/tcg_interp.sv
// Interpolates the four A,R,G,B lanes as base + u*step_u + v*step_v.
// Two register stages; depends on tcg_pkg.
module tcg_interp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcg_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  tcg_pkg::uv_t   uv_i,
  output logic           valid_o,
  output tcg_pkg::chan_t chan_o
);

  logic signed [tcg_pkg::ChProdW-1:0] pu_d [tcg_pkg::LaneCnt];
  logic signed [tcg_pkg::ChProdW-1:0] pv_d [tcg_pkg::LaneCnt];
  logic signed [tcg_pkg::ChProdW-1:0] pu_q [tcg_pkg::LaneCnt];
  logic signed [tcg_pkg::ChProdW-1:0] pv_q [tcg_pkg::LaneCnt];
  logic                               span3_q, valid3_q, valid4_q;
  tcg_pkg::chan_t                     chan_d, chan_q;

  always_comb begin
    for (int k = 0; k < tcg_pkg::LaneCnt; k++) begin
      pu_d[k] = $signed(uv_i.u)
              * $signed(cfg_i.color_step_u[k*tcg_pkg::LaneW +: tcg_pkg::LaneW]);
      pv_d[k] = $signed(uv_i.v)
              * $signed(cfg_i.color_step_v[k*tcg_pkg::LaneW +: tcg_pkg::LaneW]);
    end
  end

  // The base color is moved up to the 31 fraction bits of the products.
  always_comb begin
    for (int k = 0; k < tcg_pkg::LaneCnt; k++) begin
      chan_d.ch[k] = tcg_pkg::ChW'(pu_q[k]) + tcg_pkg::ChW'(pv_q[k])
                   + (tcg_pkg::ChW'($signed(
                        cfg_i.base_color[k*tcg_pkg::LaneW +: tcg_pkg::LaneW]))
                      <<< tcg_pkg::BaseShift);
    end
    chan_d.span_end = span3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pu_q    <= pu_d;
    pv_q    <= pv_d;
    span3_q <= uv_i.span_end;
    chan_q  <= chan_d;
  end

  assign valid_o = valid4_q;
  assign chan_o  = chan_q;

endmodule

### src/tcg_premul.sv
// Forms |c|*|a| / 2^31 for the color lanes from products of 32-bit halves, and
// the alpha fraction, with big flags. Four register stages; depends on tcg_pkg.
module tcg_premul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  tcg_pkg::chan_t chan_i,
  output logic           valid_o,
  output tcg_pkg::qval_t qval_o
);

  localparam int ColCnt = tcg_pkg::LaneCnt - 1;

  // Stage 5: magnitudes and signs.
  logic [tcg_pkg::MagW-1:0] mag_d [ColCnt];
  logic [tcg_pkg::MagW-1:0] mag_q [ColCnt];
  logic [ColCnt-1:0]        pos_d, pos5_q;
  logic [tcg_pkg::MagW-1:0] amag_d, amag_q;
  logic [tcg_pkg::QW-1:0]   aq_d, aq5_q;
  logic                     abig_d, abig5_q;
  logic signed [tcg_pkg::ChW-1:0] a_s, c_s;

  // Stage 6: partial products.
  logic [2*tcg_pkg::HalfW-1:0]                p00_q [ColCnt];
  logic [tcg_pkg::HalfW+tcg_pkg::MagHiW-1:0]  p01_q [ColCnt];
  logic [tcg_pkg::HalfW+tcg_pkg::MagHiW-1:0]  p10_q [ColCnt];
  logic [2*tcg_pkg::MagHiW-1:0]               p11_q [ColCnt];
  logic [ColCnt-1:0]                          pos6_q;
  logic [tcg_pkg::QW-1:0]                     aq6_q;
  logic                                       abig6_q;

  // Stage 7: middle sum.
  logic [tcg_pkg::MidW-1:0]     mid_q [ColCnt];
  logic [2*tcg_pkg::HalfW-1:0]  p00m_q [ColCnt];
  logic [2*tcg_pkg::MagHiW-1:0] p11m_q [ColCnt];
  logic [ColCnt-1:0]            pos7_q;
  logic [tcg_pkg::QW-1:0]       aq7_q;
  logic                         abig7_q;

  // Stage 8: final sum and overflow flags.
  logic [tcg_pkg::HsW-1:0] hsum [ColCnt];
  tcg_pkg::qval_t          qval_d, qval_q;

  logic [2:0] span_q;
  logic [3:0] valid_q;

  always_comb begin
    a_s    = $signed(chan_i.ch[tcg_pkg::AlphaLane]);
    amag_d = a_s[tcg_pkg::ChW-1] ? tcg_pkg::MagW'(-a_s) : tcg_pkg::MagW'(a_s);
    // The alpha lane passes alpha on only where it is positive.
    if (a_s > 0) begin
      aq_d   = a_s[tcg_pkg::QW-1:0];
      abig_d = |a_s[tcg_pkg::MagW-1:tcg_pkg::QW];
    end else begin
      aq_d   = '0;
      abig_d = 1'b0;
    end
    for (int k = 0; k < ColCnt; k++) begin
      c_s      = $signed(chan_i.ch[k]);
      mag_d[k] = c_s[tcg_pkg::ChW-1] ? tcg_pkg::MagW'(-c_s) : tcg_pkg::MagW'(c_s);
      pos_d[k] = ((c_s > 0) && (a_s > 0)) || ((c_s < 0) && (a_s < 0));
    end
  end

  always_comb begin
    for (int k = 0; k < ColCnt; k++) begin
      hsum[k] = {p11m_q[k], p00m_q[k][2*tcg_pkg::HalfW-1:tcg_pkg::HalfW]}
              + tcg_pkg::HsW'(mid_q[k]);
      if (pos7_q[k]) begin
        qval_d.q[k]   = {hsum[k][tcg_pkg::QW-2:0], p00m_q[k][tcg_pkg::HalfW-1]};
        qval_d.big[k] = |hsum[k][tcg_pkg::HsW-1:tcg_pkg::QW-1];
      end else begin
        qval_d.q[k]   = '0;
        qval_d.big[k] = 1'b0;
      end
    end
    qval_d.q[tcg_pkg::AlphaLane]   = aq7_q;
    qval_d.big[tcg_pkg::AlphaLane] = abig7_q;
    qval_d.span_end                = span_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    span_q  <= {span_q[1:0], chan_i.span_end};
    mag_q   <= mag_d;
    amag_q  <= amag_d;
    pos5_q  <= pos_d;
    aq5_q   <= aq_d;
    abig5_q <= abig_d;
    for (int k = 0; k < ColCnt; k++) begin
      p00_q[k] <= mag_q[k][tcg_pkg::HalfW-1:0] * amag_q[tcg_pkg::HalfW-1:0];
      p01_q[k] <= mag_q[k][tcg_pkg::HalfW-1:0]
                * amag_q[tcg_pkg::MagW-1:tcg_pkg::HalfW];
      p10_q[k] <= mag_q[k][tcg_pkg::MagW-1:tcg_pkg::HalfW]
                * amag_q[tcg_pkg::HalfW-1:0];
      p11_q[k] <= mag_q[k][tcg_pkg::MagW-1:tcg_pkg::HalfW]
                * amag_q[tcg_pkg::MagW-1:tcg_pkg::HalfW];
      mid_q[k]  <= tcg_pkg::MidW'(p01_q[k]) + tcg_pkg::MidW'(p10_q[k]);
      p00m_q[k] <= p00_q[k];
      p11m_q[k] <= p11_q[k];
    end
    pos6_q  <= pos5_q;
    aq6_q   <= aq5_q;
    abig6_q <= abig5_q;
    pos7_q  <= pos6_q;
    aq7_q   <= aq6_q;
    abig7_q <= abig6_q;
    qval_q  <= qval_d;
  end

  assign valid_o = valid_q[3];
  assign qval_o  = qval_q;

endmodule

### src/tcg_pin.sv
// Scales each lane fraction by the paint alpha and converts it to an 8-bit value
// pinned to 0..255. Two register stages; depends on tcg_pkg.
module tcg_pin (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tcg_pkg::ScaleW-1:0]  alpha_scale_i,
  input  logic                        valid_i,
  input  tcg_pkg::qval_t              qval_i,
  output logic                        valid_o,
  output tcg_pkg::pix_out_t           pix_o
);

  localparam logic [tcg_pkg::QW:0] OneQ = {1'b1, {tcg_pkg::QW{1'b0}}};

  logic [tcg_pkg::TW-1:0]      t_q   [tcg_pkg::LaneCnt];
  logic [tcg_pkg::LaneCnt-1:0] big_q;
  logic                        snz_q, span9_q, valid9_q, valid10_q;

  logic [tcg_pkg::QW:0]             tc    [tcg_pkg::LaneCnt];
  logic [tcg_pkg::QW+tcg_pkg::ByteW:0] prod [tcg_pkg::LaneCnt];
  logic [tcg_pkg::ByteW-1:0]        byte_v [tcg_pkg::LaneCnt];
  tcg_pkg::pix_out_t                pix_d, pix_q;

  always_comb begin
    for (int k = 0; k < tcg_pkg::LaneCnt; k++) begin
      tc[k]   = (t_q[k] > tcg_pkg::TW'(OneQ)) ? OneQ : t_q[k][tcg_pkg::QW:0];
      // Times 255 as times 256 minus one copy.
      prod[k] = {tc[k], {tcg_pkg::ByteW{1'b0}}}
              - (tcg_pkg::QW + tcg_pkg::ByteW + 1)'(tc[k]);
      if (big_q[k]) begin
        byte_v[k] = snz_q ? {tcg_pkg::ByteW{1'b1}} : '0;
      end else begin
        byte_v[k] = prod[k][tcg_pkg::QW+tcg_pkg::ByteW-1:tcg_pkg::QW];
      end
      pix_d.pixel_argb[k*tcg_pkg::ByteW +: tcg_pkg::ByteW] = byte_v[k];
    end
    pix_d.span_end_out = span9_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid9_q  <= 1'b0;
      valid10_q <= 1'b0;
    end else begin
      valid9_q  <= valid_i;
      valid10_q <= valid9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < tcg_pkg::LaneCnt; k++) begin
      t_q[k] <= qval_i.q[k] * alpha_scale_i;
    end
    big_q   <= qval_i.big;
    snz_q   <= |alpha_scale_i;
    span9_q <= qval_i.span_end;
    pix_q   <= pix_d;
  end

  assign valid_o = valid10_q;
  assign pix_o   = pix_q;

endmodule

### src/triangle_color_gradient_shader_core.sv
// Smooth-shaded triangle color core: one pixel position in, one premultiplied ARGB pixel out.
// done_o is high with the result of each pixel whose start was taken.
// Throughput: one pixel per cycle; busy stays low, a new pixel may enter every cycle.
// Stages: two map, two interpolate, four for the split color-times-alpha product, two scale.
// The receiver cannot stall: each result shows for exactly one cycle with done_o.
// Reset clears all stage valid bits and loads the registers (paint alpha one, others 0).
module triangle_color_gradient_shader_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tcg_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  tcg_pkg::pix_in_t               pix_i,
  output logic                           done_o,
  output tcg_pkg::pix_out_t              pix_o
);

  tcg_pkg::cfg_t   cfg_q;
  logic            accept;
  logic            map_valid, interp_valid, premul_valid;
  tcg_pkg::uv_t    uv;
  tcg_pkg::chan_t  chan;
  tcg_pkg::qval_t  qval;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_color   <= '0;
      cfg_q.color_step_u <= '0;
      cfg_q.color_step_v <= '0;
      cfg_q.map_u_coeffs <= '0;
      cfg_q.map_v_coeffs <= '0;
      cfg_q.map_offsets  <= '0;
      cfg_q.alpha_scale  <= tcg_pkg::AlphaOne;
    end else if (cfg_we_i) begin
      case (tcg_pkg::cfg_reg_e'(cfg_idx_i))
        tcg_pkg::RegBaseColor:  cfg_q.base_color   <= cfg_data_i;
        tcg_pkg::RegColorStepU: cfg_q.color_step_u <= cfg_data_i;
        tcg_pkg::RegColorStepV: cfg_q.color_step_v <= cfg_data_i;
        tcg_pkg::RegMapU:       cfg_q.map_u_coeffs <= cfg_data_i;
        tcg_pkg::RegMapV:       cfg_q.map_v_coeffs <= cfg_data_i;
        tcg_pkg::RegMapOffsets: cfg_q.map_offsets  <= cfg_data_i;
        tcg_pkg::RegAlphaScale: cfg_q.alpha_scale  <= cfg_data_i[tcg_pkg::ScaleW-1:0];
        default: begin
          // Unknown index: the write is dropped.
        end
      endcase
    end
  end

  tcg_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (accept),
    .pix_i   (pix_i),
    .valid_o (map_valid),
    .uv_o    (uv)
  );

  tcg_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (map_valid),
    .uv_i    (uv),
    .valid_o (interp_valid),
    .chan_o  (chan)
  );

  tcg_premul u_premul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (interp_valid),
    .chan_i  (chan),
    .valid_o (premul_valid),
    .qval_o  (qval)
  );

  tcg_pin u_pin (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .alpha_scale_i (cfg_q.alpha_scale),
    .valid_i       (premul_valid),
    .qval_i        (qval),
    .valid_o       (done_o),
    .pix_o         (pix_o)
  );

  // Every accepted transaction comes out with done_o, and nothing else does.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##10 done_o)
    else $error("accepted pixel did not produce a result after ten cycles");

  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 10))
    else $error("result strobe without a matching accepted pixel");

  a_span_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pix_o.span_end_out == $past(pix_i.span_end, 10)))
    else $error("span end marker does not match its pixel");

endmodule
